// ===== rtl/tga_psd_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_psd_pkg
// Shared types and codes for the tga pixel stream decoder.
// ----------------------------------------------------------------------------
package tga_psd_pkg;

  // pixel format codes
  localparam logic [1:0] FMT_555  = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RLE_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd1;
  localparam logic [1:0] CFG_PIXEL_TOTAL  = 2'd2;

  localparam int unsigned CfgDataW = 32;

  // rle header byte split
  localparam logic [7:0] RUN_THRESHOLD = 8'd128;
  localparam logic [7:0] RUN_BIAS      = 8'd127;

  // reset values of the configuration registers
  localparam logic        RLE_RESET    = 1'b0;
  localparam logic [1:0]  FORMAT_RESET = FMT_BGR;
  localparam logic [31:0] TOTAL_RESET  = 32'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       format_error;
  } pix_t;

  typedef struct packed {
    logic        rle_enable;
    logic [1:0]  pixel_format;
    logic [31:0] pixel_total;
  } cfg_t;

endpackage

// ===== rtl/tga_psd_if.sv =====
// ----------------------------------------------------------------------------
// tga_psd_byte_if / tga_psd_pixel_if
// Valid/ready channels for the byte input and the pixel output.
// ----------------------------------------------------------------------------
interface tga_psd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_psd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       image_done;
  logic       format_error;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_count, output image_done, output format_error,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_count, input image_done, input format_error,
                  output ready);
endinterface

// ===== rtl/tga_psd_core.sv =====
// ----------------------------------------------------------------------------
// tga_psd_core
// Packet and pixel state; consumes one byte per step and forms a pixel.
// ----------------------------------------------------------------------------
module tga_psd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  tga_psd_pkg::cfg_t   cfg_i,
  output logic                res_valid_o,
  output tga_psd_pkg::pix_t   res_o
);

  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [23:0] pix_bytes_q, pix_bytes_d;
  logic        expect_hdr_q, expect_hdr_d;
  logic        is_run_q, is_run_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] emitted_q, emitted_d;

  logic        fmt_err;
  logic [1:0]  last_pos;
  logic [15:0] v555;
  logic [31:0] remaining;
  logic [31:0] count;
  logic        done;
  logic [7:0]  red, green, blue, alpha;

  assign fmt_err = cfg_i.rle_enable && (cfg_i.pixel_format == tga_psd_pkg::FMT_555);

  always_comb begin
    case (cfg_i.pixel_format)
      tga_psd_pkg::FMT_555: last_pos = 2'd1;
      tga_psd_pkg::FMT_BGR: last_pos = 2'd2;
      default:              last_pos = 2'd3;
    endcase
  end

  // channel unpack, first and third stored bytes swapped
  assign v555 = {byte_i, pix_bytes_q[7:0]};
  always_comb begin
    case (cfg_i.pixel_format)
      tga_psd_pkg::FMT_555: begin
        blue  = {v555[4:0], 3'b000};
        green = {v555[9:5], 3'b000};
        red   = {v555[14:10], 3'b000};
        alpha = 8'hff;
      end
      tga_psd_pkg::FMT_BGR: begin
        blue  = pix_bytes_q[7:0];
        green = pix_bytes_q[15:8];
        red   = byte_i;
        alpha = 8'hff;
      end
      default: begin
        blue  = pix_bytes_q[7:0];
        green = pix_bytes_q[15:8];
        red   = pix_bytes_q[23:16];
        alpha = byte_i;
      end
    endcase
  end

  // run length clipped to what is left of the image
  always_comb begin
    logic [31:0] want;
    want = (cfg_i.rle_enable && is_run_q && (left_q != 8'd0)) ? {24'd0, left_q} : 32'd1;
    remaining = (cfg_i.pixel_total > emitted_q) ? (cfg_i.pixel_total - emitted_q) : 32'd1;
    count = (want > remaining) ? remaining : want;
    done  = (count == remaining);
  end

  always_comb begin
    byte_pos_d   = byte_pos_q;
    pix_bytes_d  = pix_bytes_q;
    expect_hdr_d = expect_hdr_q;
    is_run_d     = is_run_q;
    left_d       = left_q;
    emitted_d    = emitted_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (fmt_err) begin
      byte_pos_d         = '0;
      pix_bytes_d        = '0;
      expect_hdr_d       = 1'b1;
      is_run_d           = 1'b0;
      left_d             = '0;
      emitted_d          = '0;
      res_valid_o        = 1'b1;
      res_o.repeat_count = 8'd1;
      res_o.format_error = 1'b1;
    end else if (cfg_i.rle_enable && expect_hdr_q) begin
      if (byte_i < tga_psd_pkg::RUN_THRESHOLD) begin
        is_run_d = 1'b0;
        left_d   = byte_i + 8'd1;
      end else begin
        is_run_d = 1'b1;
        left_d   = byte_i - tga_psd_pkg::RUN_BIAS;
      end
      expect_hdr_d = 1'b0;
      byte_pos_d   = '0;
      pix_bytes_d  = '0;
    end else if (byte_pos_q < last_pos) begin
      case (byte_pos_q)
        2'd0:    pix_bytes_d[7:0]   = byte_i;
        2'd1:    pix_bytes_d[15:8]  = byte_i;
        default: pix_bytes_d[23:16] = byte_i;
      endcase
      byte_pos_d = byte_pos_q + 2'd1;
    end else begin
      byte_pos_d  = '0;
      pix_bytes_d = '0;
      if (cfg_i.rle_enable) begin
        if (is_run_q || (left_q <= 8'd1)) begin
          left_d       = '0;
          expect_hdr_d = 1'b1;
        end else begin
          left_d = left_q - 8'd1;
        end
      end
      emitted_d = emitted_q + count;
      if (done) begin
        expect_hdr_d = 1'b1;
        is_run_d     = 1'b0;
        left_d       = '0;
        emitted_d    = '0;
      end
      res_valid_o        = 1'b1;
      res_o.red          = red;
      res_o.green        = green;
      res_o.blue         = blue;
      res_o.alpha        = alpha;
      res_o.repeat_count = count[7:0];
      res_o.image_done   = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      pix_bytes_q  <= '0;
      expect_hdr_q <= 1'b1;
      is_run_q     <= 1'b0;
      left_q       <= '0;
      emitted_q    <= '0;
    end else if (step_i) begin
      byte_pos_q   <= byte_pos_d;
      pix_bytes_q  <= pix_bytes_d;
      expect_hdr_q <= expect_hdr_d;
      is_run_q     <= is_run_d;
      left_q       <= left_d;
      emitted_q    <= emitted_d;
    end
  end

endmodule

// ===== rtl/tga_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Decodes tga pixel-data bytes (raw or rle) into rgba pixels with run counts.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     carries
//  byte_in     in   valid/ready   data_byte
//  pixel_out   out  valid/ready   red green blue alpha repeat_count image_done
//                                 format_error
//  cfg_*       in   write enable  rle_enable, pixel_format, pixel_total
//
// one byte is taken every cycle while byte_in is not stalled; a pixel reaches pixel_out
// after its last byte is accepted through the input register, then the pixel register.
// byte_in stalls only when both the input register and the pixel register are
// full and pixel_out is not ready.
// reset clears the packet state and loads rle off, 24-bit format, one pixel.
module tga_pixel_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tga_psd_byte_if.sink                  byte_in,
  tga_psd_pixel_if.source               pixel_out,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tga_psd_pkg::CfgDataW-1:0] cfg_data_i
);

  tga_psd_pkg::cfg_t cfg_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              out_vld_q;
  tga_psd_pkg::pix_t out_q;
  logic              advance;
  logic              res_valid;
  tga_psd_pkg::pix_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_enable   <= tga_psd_pkg::RLE_RESET;
      cfg_q.pixel_format <= tga_psd_pkg::FORMAT_RESET;
      cfg_q.pixel_total  <= tga_psd_pkg::TOTAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tga_psd_pkg::CFG_RLE_ENABLE:   cfg_q.rle_enable   <= cfg_data_i[0];
        tga_psd_pkg::CFG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data_i[1:0];
        tga_psd_pkg::CFG_PIXEL_TOTAL:  cfg_q.pixel_total  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_vld_q && (!out_vld_q || pixel_out.ready);
  assign byte_in.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_in.ready) begin
      in_vld_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte_q <= byte_in.data_byte;
    end
  end

  tga_psd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_vld_q <= 1'b1;
    end else if (pixel_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign pixel_out.valid        = out_vld_q;
  assign pixel_out.red          = out_q.red;
  assign pixel_out.green        = out_q.green;
  assign pixel_out.blue         = out_q.blue;
  assign pixel_out.alpha        = out_q.alpha;
  assign pixel_out.repeat_count = out_q.repeat_count;
  assign pixel_out.image_done   = out_q.image_done;
  assign pixel_out.format_error = out_q.format_error;

endmodule

// ===== rtl/tga_psd_checker.sv =====
// ----------------------------------------------------------------------------
// tga_psd_checker
// Port-level checks on the pixel output of the decoder.
// ----------------------------------------------------------------------------
module tga_psd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic [7:0] repeat_count_i,
  input logic       image_done_i,
  input logic       format_error_i
);

  // a waiting item is not withdrawn
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pixel valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({red_i, green_i, blue_i, alpha_i,
                                             repeat_count_i, image_done_i,
                                             format_error_i}))
    else $error("pixel payload changed while stalled");

  // error items carry no pixel and never end an image
  a_error_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && format_error_i |-> red_i == 8'd0 && green_i == 8'd0 &&
                                      blue_i == 8'd0 && alpha_i == 8'd0 &&
                                      repeat_count_i == 8'd1 && !image_done_i)
    else $error("format error item with pixel data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> repeat_count_i != 8'd0 && repeat_count_i <= 8'd128)
    else $error("repeat count out of range");

endmodule

bind tga_pixel_stream_decoder tga_psd_checker u_tga_psd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (pixel_out.valid),
  .out_ready_i    (pixel_out.ready),
  .red_i          (pixel_out.red),
  .green_i        (pixel_out.green),
  .blue_i         (pixel_out.blue),
  .alpha_i        (pixel_out.alpha),
  .repeat_count_i (pixel_out.repeat_count),
  .image_done_i   (pixel_out.image_done),
  .format_error_i (pixel_out.format_error)
);
